FILE: rtl/assert_macros.svh
// Assertion helpers for the RTL file that checks its own logic (spd_out_buf).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, masked during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/spd_pkg.sv
`default_nettype none

package spd_pkg;

   // Hard upper bound on payload length, on top of the programmable limit
   localparam int MaxPayload = 1024;

   // Register indexes of the configuration port
   localparam logic [1:0] RegSync    = 2'd0;
   localparam logic [1:0] RegVersion = 2'd1;
   localparam logic [1:0] RegMaxLen  = 2'd2;

   // Register reset values
   localparam logic [7:0]  SyncReset    = 8'd255;
   localparam logic [7:0]  VersionReset = 8'd254;
   localparam logic [10:0] MaxLenReset  = 11'd1024;

   typedef enum logic [2:0] {
      StOk        = 3'd0,
      StBadVersion = 3'd1,
      StBadLenCs  = 3'd2,
      StTooLong   = 3'd3,
      StBadDataCs = 3'd4
   } status_type;

   typedef enum logic {
      KindPayload = 1'b0,
      KindStatus  = 1'b1
   } kind_type;

   // One result item
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [9:0]  byte_index;
      logic [15:0] topic_id;
      status_type  status;
      logic        packet_end;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/spd_parser.sv
`default_nettype none

module spd_parser #(
   parameter int MaxPayload = spd_pkg::MaxPayload
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [1:0]          csr_index,
   input  wire logic [10:0]         csr_wdata,
   input  wire logic                in_accept,
   input  wire logic [7:0]          rx_byte,
   output logic                     result_valid,
   output spd_pkg::result_type      result
);

   typedef enum logic [8:0] {
      PhHunt    = 9'b000000001,
      PhVersion = 9'b000000010,
      PhLenLo   = 9'b000000100,
      PhLenHi   = 9'b000001000,
      PhLenCs   = 9'b000010000,
      PhTopicLo = 9'b000100000,
      PhTopicHi = 9'b001000000,
      PhPayload = 9'b010000000,
      PhDataCs  = 9'b100000000
   } phase_type;

   localparam logic [15:0] MaxPayloadW = 16'(MaxPayload);

   logic [7:0]  sync_ff;
   logic [7:0]  version_ff;
   logic [10:0] max_len_ff;

   phase_type   phase_ff,  phase_in;
   logic [15:0] length_ff, length_in;
   logic [7:0]  len_sum_ff, len_sum_in;
   logic [7:0]  data_sum_ff, data_sum_in;
   logic [15:0] topic_ff, topic_in;
   logic [10:0] count_ff, count_in;

   logic [15:0] limit;
   logic [10:0] count_inc;
   logic        has_result;

   // Configuration registers; an unknown index is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff    <= spd_pkg::SyncReset;
         version_ff <= spd_pkg::VersionReset;
         max_len_ff <= spd_pkg::MaxLenReset;
      end else if (csr_wr_en) begin
         case (csr_index)
            spd_pkg::RegSync:    sync_ff    <= csr_wdata[7:0];
            spd_pkg::RegVersion: version_ff <= csr_wdata[7:0];
            spd_pkg::RegMaxLen:  max_len_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective length limit is the smaller of the register and the hard bound
   assign limit = (MaxPayloadW < {5'd0, max_len_ff}) ? MaxPayloadW : {5'd0, max_len_ff};
   assign count_inc = count_ff + 11'd1;

   // Next state and result for the byte on the input
   always_comb begin
      phase_in    = phase_ff;
      length_in   = length_ff;
      len_sum_in  = len_sum_ff;
      data_sum_in = data_sum_ff;
      topic_in    = topic_ff;
      count_in    = count_ff;
      has_result  = 1'b0;
      result.kind       = spd_pkg::KindStatus;
      result.data_byte  = 8'd0;
      result.byte_index = 10'd0;
      result.topic_id   = 16'd0;
      result.status     = spd_pkg::StOk;
      result.packet_end = 1'b1;
      case (phase_ff)
         PhHunt: begin
            if (rx_byte == sync_ff) phase_in = PhVersion;
         end
         PhVersion: begin
            if (rx_byte != version_ff) begin
               has_result    = 1'b1;
               result.status = spd_pkg::StBadVersion;
               phase_in      = PhHunt;
            end else begin
               phase_in = PhLenLo;
            end
         end
         PhLenLo: begin
            length_in  = {8'd0, rx_byte};
            len_sum_in = rx_byte;
            phase_in   = PhLenHi;
         end
         PhLenHi: begin
            length_in  = {rx_byte, length_ff[7:0]};
            len_sum_in = len_sum_ff + rx_byte;
            phase_in   = PhLenCs;
         end
         PhLenCs: begin
            // checksum is 255 minus the byte sum, that is its complement
            if (rx_byte != ~len_sum_ff) begin
               has_result    = 1'b1;
               result.status = spd_pkg::StBadLenCs;
               phase_in      = PhHunt;
            end else if (length_ff > limit) begin
               has_result    = 1'b1;
               result.status = spd_pkg::StTooLong;
               phase_in      = PhHunt;
            end else begin
               phase_in = PhTopicLo;
            end
         end
         PhTopicLo: begin
            topic_in    = {8'd0, rx_byte};
            data_sum_in = rx_byte;
            phase_in    = PhTopicHi;
         end
         PhTopicHi: begin
            topic_in    = {rx_byte, topic_ff[7:0]};
            data_sum_in = data_sum_ff + rx_byte;
            count_in    = 11'd0;
            phase_in    = (length_ff == 16'd0) ? PhDataCs : PhPayload;
         end
         PhPayload: begin
            has_result        = 1'b1;
            result.kind       = spd_pkg::KindPayload;
            result.data_byte  = rx_byte;
            result.byte_index = count_ff[9:0];
            result.topic_id   = topic_ff;
            result.packet_end = 1'b0;
            data_sum_in       = data_sum_ff + rx_byte;
            count_in          = count_inc;
            if ({5'd0, count_inc} >= length_ff) phase_in = PhDataCs;
         end
         PhDataCs: begin
            has_result      = 1'b1;
            result.topic_id = topic_ff;
            result.status   = (rx_byte == ~data_sum_ff) ? spd_pkg::StOk
                                                        : spd_pkg::StBadDataCs;
            phase_in        = PhHunt;
         end
         default: begin
            phase_in = PhHunt;
         end
      endcase
   end

   assign result_valid = in_accept & has_result;

   // Phase is control state; the rest is written before it is read
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhHunt;
      end else if (in_accept) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         length_ff   <= length_in;
         len_sum_ff  <= len_sum_in;
         data_sum_ff <= data_sum_in;
         topic_ff    <= topic_in;
         count_ff    <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/spd_out_buf.sv
`default_nettype none

`include "assert_macros.svh"

module spd_out_buf (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire spd_pkg::result_type push_item,
   output logic                     push_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output spd_pkg::result_type      rsp_item
);

   logic                  out_valid_ff;
   spd_pkg::result_type   out_item_ff;
   logic                  skid_valid_ff;
   spd_pkg::result_type   skid_item_ff;
   logic                  pop;

   assign pop        = out_valid_ff & rsp_ready;
   assign push_ready = ~skid_valid_ff;
   assign rsp_valid  = out_valid_ff;
   assign rsp_item   = out_item_ff;

   // Refill the output stage from the skid stage first, else from the parser
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop || !out_valid_ff) begin
         out_item_ff <= skid_valid_ff ? skid_item_ff : push_item;
      end else if (push) begin
         skid_item_ff <= push_item;
      end
   end

   `ASSERT_IMPLIES(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `ASSERT_NEXT(a_skid_holds, clock, reset, skid_valid_ff && !pop, skid_valid_ff)
   `ASSERT_NEXT(a_push_to_skid, clock, reset, push && out_valid_ff && !pop, skid_valid_ff)

endmodule

`default_nettype wire

FILE: rtl/serial_packet_deframer.sv
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tdata[7:0] rx_byte
// rsp      out        rsp_tvalid/rsp_tready  tdata: data_byte, byte_index, topic_id, status;
//                                            tuser: kind; tlast: packet_end
// csr      in         csr_wr_en              csr_index, csr_wdata
//
// One received byte is taken per cycle while req_tready is high; its result, if
// any, is registered in the output register, or first in the skid register, for rsp.
// A two-entry output stage (output register plus skid register) lets input
// continue while one result waits; req_tready drops only when both are full.
// Reset is synchronous, active high, and puts the block back to sync hunting.
`default_nettype none

module serial_packet_deframer #(
   parameter int MaxPayload = spd_pkg::MaxPayload
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [7:0] data_byte, [17:8] byte_index,
                                         // [33:18] topic_id, [36:34] status, [39:37] zero
   output logic [0:0]       rsp_tuser,   // [0] kind
   output logic             rsp_tlast,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [10:0] csr_wdata
);

   logic                  in_accept;
   logic                  result_valid;
   spd_pkg::result_type   result;
   spd_pkg::result_type   rsp_item;

   assign in_accept = req_tvalid & req_tready;

   spd_parser #(
      .MaxPayload (MaxPayload)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .in_accept    (in_accept),
      .rx_byte      (req_tdata),
      .result_valid (result_valid),
      .result       (result)
   );

   spd_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (result_valid),
      .push_item  (result),
      .push_ready (req_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_item   (rsp_item)
   );

   // Pack the result item onto the stream
   assign rsp_tdata = {3'd0, rsp_item.status, rsp_item.topic_id,
                       rsp_item.byte_index, rsp_item.data_byte};
   assign rsp_tuser = rsp_item.kind;
   assign rsp_tlast = rsp_item.packet_end;

endmodule

`default_nettype wire
